// ===== rtl/core/tree_nearest_marked_distance_assert.svh =====
// Assertion macros for the nearest marked distance block.
`ifndef TREE_NEAREST_MARKED_DISTANCE_ASSERT_SVH
`define TREE_NEAREST_MARKED_DISTANCE_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define TNMD_ASSERT_ALWAYS(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define TNMD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tnmd_pkg.sv =====
// Constants and types shared by the nearest marked distance block.
package tnmd_pkg;

   localparam int CITY_W   = 12;
   localparam int LINK_W   = 13;
   localparam int DIST_W   = 12;
   localparam int CITY_SLOTS = 4096;
   localparam int MAX_LINKS  = 8192;

   localparam logic [DIST_W-1:0] DIST_NONE = {DIST_W{1'b1}};
   localparam logic [LINK_W:0]   LINK_NONE = 14'(MAX_LINKS);

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_MARK  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   typedef enum logic [11:0] {
      S_CLEAR  = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_ADD_RD = 12'b0000_0000_0100,
      S_ADD_WR = 12'b0000_0000_1000,
      S_MK_CHK = 12'b0000_0001_0000,
      S_DEQ    = 12'b0000_0010_0000,
      S_DEQW   = 12'b0000_0100_0000,
      S_HEAD   = 12'b0000_1000_0000,
      S_LINK   = 12'b0001_0000_0000,
      S_LINKW  = 12'b0010_0000_0000,
      S_NB     = 12'b0100_0000_0000,
      S_QRY    = 12'b1000_0000_0000
   } state_type;

endpackage

// ===== rtl/core/tree_nearest_marked_distance.sv =====
// Tree of cities with per-city distance to the nearest marked city.
// After reset a clearing pass over every city slot runs before the first request is taken.
// Query: the distance is read, then registered once the response slot is free.
// Add edge: one link per direction, each via a read state and a write state.
// Mark: a breadth-first walk that dequeues each city and reads each of its links.
// A request is taken only in the idle state; one request is in work at a time.
`include "tree_nearest_marked_distance_assert.svh"

module tree_nearest_marked_distance import tnmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic [CITY_W-1:0] req_city_a,
   input  logic [CITY_W-1:0] req_city_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DIST_W-1:0] rsp_distance
);

   logic [DIST_W-1:0] dist_mem  [CITY_SLOTS];
   logic [LINK_W:0]   head_mem  [CITY_SLOTS];
   logic [LINK_W-1:0] tail_mem  [CITY_SLOTS];
   logic [LINK_W:0]   next_mem  [MAX_LINKS];
   logic [CITY_W-1:0] city_mem  [MAX_LINKS];
   logic [CITY_W-1:0] queue_mem [CITY_SLOTS];

   state_type         state_ff, state_in;
   logic [CITY_W-1:0] owner_ff, owner_in;
   logic [CITY_W-1:0] nb_ff, nb_in;
   logic              second_ff, second_in;
   logic [LINK_W:0]   count_ff, count_in;
   logic [CITY_W:0]   clr_ff, clr_in;
   logic [CITY_W:0]   j_ff, j_in;
   logic [CITY_W:0]   end_ff, end_in;
   logic [CITY_W:0]   k_ff, k_in;
   logic [CITY_W:0]   level_ff, level_in;
   logic [LINK_W:0]   it_ff, it_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;

   logic              dist_we, dist_re;
   logic [CITY_W-1:0] dist_waddr, dist_raddr;
   logic [DIST_W-1:0] dist_wdata, dist_rd_ff;
   logic              head_we, head_re;
   logic [CITY_W-1:0] head_waddr, head_raddr;
   logic [LINK_W:0]   head_wdata, head_rd_ff;
   logic              tail_we, tail_re;
   logic [LINK_W-1:0] tail_rd_ff;
   logic              next_we, next_re;
   logic [LINK_W-1:0] next_waddr, next_raddr;
   logic [LINK_W:0]   next_wdata, next_rd_ff;
   logic              city_we, city_re;
   logic [CITY_W-1:0] city_rd_ff;
   logic              queue_we, queue_re;
   logic [CITY_W-1:0] queue_waddr, queue_wdata, queue_rd_ff;
   logic              rsp_free;
   logic [LINK_W+1:0] count_plus;

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign count_plus   = {1'b0, count_ff} + 15'd2;

   always_comb begin
      state_in     = state_ff;
      owner_in     = owner_ff;
      nb_in        = nb_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      j_in         = j_ff;
      end_in       = end_ff;
      k_in         = k_ff;
      level_in     = level_ff;
      it_in        = it_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_dist_in  = rsp_dist_ff;
      dist_we = 1'b0; dist_re = 1'b0;
      dist_waddr = clr_ff[CITY_W-1:0]; dist_raddr = req_city_a; dist_wdata = DIST_NONE;
      head_we = 1'b0; head_re = 1'b0;
      head_waddr = clr_ff[CITY_W-1:0]; head_raddr = owner_ff; head_wdata = LINK_NONE;
      tail_we = 1'b0; tail_re = 1'b0;
      next_we = 1'b0; next_re = 1'b0;
      next_waddr = count_ff[LINK_W-1:0]; next_raddr = it_ff[LINK_W-1:0];
      next_wdata = LINK_NONE;
      city_we = 1'b0; city_re = 1'b0;
      queue_we = 1'b0; queue_re = 1'b0;
      queue_waddr = k_ff[CITY_W-1:0]; queue_wdata = nb_ff;
      case (state_ff)
         S_CLEAR: begin
            dist_we = 1'b1;
            head_we = 1'b1;
            clr_in  = clr_ff + 13'd1;
            if (clr_ff[CITY_W-1:0] == DIST_NONE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               owner_in  = req_city_a;
               nb_in     = req_city_b;
               second_in = 1'b0;
               case (req_opcode)
                  OP_ADD: begin
                     if (count_plus <= 15'(MAX_LINKS)) begin
                        state_in = S_ADD_RD;
                     end
                  end
                  OP_MARK: begin
                     dist_re  = 1'b1;
                     state_in = S_MK_CHK;
                  end
                  OP_QUERY: begin
                     dist_re  = 1'b1;
                     state_in = S_QRY;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ADD_RD: begin
            head_re  = 1'b1;
            tail_re  = 1'b1;
            city_we  = 1'b1;
            next_we  = 1'b1;
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            if (head_rd_ff[LINK_W]) begin
               head_we    = 1'b1;
               head_waddr = owner_ff;
               head_wdata = count_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = tail_rd_ff;
               next_wdata = count_ff;
            end
            tail_we  = 1'b1;
            count_in = count_ff + 14'd1;
            if (second_ff) begin
               state_in = S_IDLE;
            end else begin
               second_in = 1'b1;
               owner_in  = nb_ff;
               nb_in     = owner_ff;
               state_in  = S_ADD_RD;
            end
         end
         S_MK_CHK: begin
            if (dist_rd_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               queue_we    = 1'b1;
               queue_waddr = '0;
               queue_wdata = owner_ff;
               j_in        = '0;
               end_in      = 13'd1;
               k_in        = 13'd1;
               level_in    = '0;
               state_in    = S_DEQ;
            end
         end
         S_DEQ: begin
            if (j_ff == end_ff) begin
               if (k_ff == end_ff) begin
                  state_in = S_IDLE;
               end else begin
                  end_in   = k_ff;
                  level_in = level_ff + 13'd1;
               end
            end else begin
               queue_re = 1'b1;
               state_in = S_DEQW;
            end
         end
         S_DEQW: begin
            dist_we    = 1'b1;
            dist_waddr = queue_rd_ff;
            dist_wdata = level_ff[DIST_W-1:0];
            head_re    = 1'b1;
            head_raddr = queue_rd_ff;
            j_in       = j_ff + 13'd1;
            state_in   = S_HEAD;
         end
         S_HEAD: begin
            it_in    = head_rd_ff;
            state_in = S_LINK;
         end
         S_LINK: begin
            if (it_ff[LINK_W]) begin
               state_in = S_DEQ;
            end else begin
               city_re  = 1'b1;
               next_re  = 1'b1;
               state_in = S_LINKW;
            end
         end
         S_LINKW: begin
            nb_in      = city_rd_ff;
            it_in      = next_rd_ff;
            dist_re    = 1'b1;
            dist_raddr = city_rd_ff;
            state_in   = S_NB;
         end
         S_NB: begin
            if (({2'b0, dist_rd_ff} > ({1'b0, level_ff} + 14'd1)) && !k_ff[CITY_W]) begin
               queue_we = 1'b1;
               k_in     = k_ff + 13'd1;
            end
            state_in = S_LINK;
         end
         S_QRY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_dist_in  = dist_rd_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         second_ff    <= 1'b0;
         j_ff         <= '0;
         end_ff       <= '0;
         k_ff         <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         second_ff    <= second_in;
         j_ff         <= j_in;
         end_ff       <= end_in;
         k_ff         <= k_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      owner_ff    <= owner_in;
      nb_ff       <= nb_in;
      it_ff       <= it_in;
      rsp_dist_ff <= rsp_dist_in;
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (dist_re) begin
         dist_rd_ff <= dist_mem[dist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (head_re) begin
         head_rd_ff <= head_mem[head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[owner_ff] <= count_ff[LINK_W-1:0];
      end
      if (tail_re) begin
         tail_rd_ff <= tail_mem[owner_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (next_re) begin
         next_rd_ff <= next_mem[next_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (city_we) begin
         city_mem[count_ff[LINK_W-1:0]] <= nb_ff;
      end
      if (city_re) begin
         city_rd_ff <= city_mem[it_ff[LINK_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      if (queue_re) begin
         queue_rd_ff <= queue_mem[j_ff[CITY_W-1:0]];
      end
   end

   `TNMD_ASSERT_ALWAYS(a_link_bound, count_ff <= LINK_NONE, "link count beyond pool")
   `TNMD_ASSERT_ALWAYS(a_queue_order, (j_ff <= end_ff) && (end_ff <= k_ff), "walk queue order broken")
   `TNMD_ASSERT_NEXT(a_query_out, (state_ff == S_QRY) && rsp_free, rsp_valid_ff && (state_ff == S_IDLE), "query result not loaded")
   `TNMD_ASSERT_NEXT(a_clear_hold, state_ff == S_CLEAR, !req_ready || clr_ff[CITY_W], "request taken during clear")

endmodule

// ===== sim/tb_tree_nearest_marked_distance.sv =====
// Self-checking testbench for the tree nearest marked distance block.

class distance_scoreboard;
   bit [11:0] nearest[4096];
   int        head[4096];
   int        tail[4096];
   int        next_link[8192];
   int        link_to[8192];
   int        links_used;
   int        walk[4096];
   bit [11:0] expected_distance[$];
   int        mismatches;
   int        queries_checked;
   int        marks_seen;
   int        adds_seen;

   function new();
      for (int i = 0; i < 4096; i++) begin
         nearest[i] = 12'hFFF;
         head[i] = 8192;
      end
      links_used = 0;
      mismatches = 0;
      queries_checked = 0;
      marks_seen = 0;
      adds_seen = 0;
   endfunction

   function void append(int owner, int nb);
      int idx;
      idx = links_used;
      links_used++;
      link_to[idx] = nb;
      next_link[idx] = 8192;
      if (head[owner] == 8192) head[owner] = idx;
      else next_link[tail[owner]] = idx;
      tail[owner] = idx;
   endfunction

   function void spread(int src);
      int qs, qe, k, lvl, c, it, nb;
      if (nearest[src] == 0) return;
      walk[0] = src;
      qs = 0;
      qe = 1;
      lvl = 0;
      while (qs < qe) begin
         k = qe;
         for (int j = qs; j < qe; j++) begin
            c = walk[j];
            nearest[c] = lvl[11:0];
            it = head[c];
            while (it < 8192) begin
               nb = link_to[it];
               if (int'(nearest[nb]) > lvl + 1 && k < 4096) begin
                  walk[k] = nb;
                  k++;
               end
               it = next_link[it];
            end
         end
         qs = qe;
         qe = k;
         lvl++;
      end
   endfunction

   function void note_request(bit [1:0] op, bit [11:0] a, bit [11:0] b);
      case (op)
         tnmd_pkg::OP_ADD: begin
            adds_seen++;
            if (links_used + 2 <= 8192) begin
               append(a, b);
               append(b, a);
            end
         end
         tnmd_pkg::OP_MARK: begin
            marks_seen++;
            spread(a);
         end
         tnmd_pkg::OP_QUERY: expected_distance.push_back(nearest[a]);
         default: ;
      endcase
   endfunction

   function void check_distance(bit [11:0] got);
      bit [11:0] want;
      if (expected_distance.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response, distance %0d", got);
         return;
      end
      want = expected_distance.pop_front();
      queries_checked++;
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) $display("distance mismatch: expected %0d, got %0d", want, got);
      end
   endfunction
endclass

module tb_tree_nearest_marked_distance;
   timeunit 1ns;
   timeprecision 1ps;
   import tnmd_pkg::*;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [1:0]        req_opcode = OP_ADD;
   logic [CITY_W-1:0] req_city_a = '0;
   logic [CITY_W-1:0] req_city_b = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [DIST_W-1:0] rsp_distance;

   distance_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;
   int city_pool[$];

   tree_nearest_marked_distance dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_distance(rsp_distance);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 300000) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_request(bit [1:0] op, bit [11:0] a, bit [11:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_city_a <= a;
      req_city_b <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, a, b);
      @(negedge clock);
   endtask

   task automatic random_requests(int count);
      int pick;
      for (int i = 0; i < 4; i++) city_pool.push_back($urandom_range(4095));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 40)
            send_request(OP_ADD, city_pool[$urandom_range(city_pool.size() - 1)],
                         city_pool[$urandom_range(city_pool.size() - 1)]);
         else if (pick < 60)
            send_request(OP_MARK, city_pool[$urandom_range(city_pool.size() - 1)],
                         $urandom_range(4095));
         else if (pick < 95)
            send_request(OP_QUERY, city_pool[$urandom_range(city_pool.size() - 1)],
                         $urandom_range(4095));
         else
            send_request(2'd3, $urandom_range(4095), $urandom_range(4095));
         if ($urandom_range(9) == 0) city_pool.push_back($urandom_range(4095));
      end
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (sb.expected_distance.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 21;
      recv_idle_pct = 45;
      send_request(OP_QUERY, 12'd0, 12'd0);
      send_request(OP_QUERY, 12'd4095, 12'd4095);
      send_request(OP_MARK, 12'd100, 12'd0);
      send_request(OP_ADD, 12'd0, 12'd4095);
      send_request(OP_ADD, 12'd4095, 12'd1365);
      send_request(OP_ADD, 12'd2730, 12'd0);
      send_request(OP_ADD, 12'd2730, 12'd2730);
      send_request(OP_ADD, 12'd0, 12'd4095);
      send_request(OP_MARK, 12'd0, 12'd4095);
      send_request(OP_QUERY, 12'd0, 12'd0);
      send_request(OP_QUERY, 12'd4095, 12'd0);
      send_request(OP_QUERY, 12'd1365, 12'd0);
      send_request(OP_QUERY, 12'd2730, 12'd0);
      send_request(OP_MARK, 12'd0, 12'd0);
      send_request(2'd3, 12'd1365, 12'd2730);
      send_request(OP_MARK, 12'd1365, 12'd0);
      send_request(OP_QUERY, 12'd4095, 12'd0);
      send_request(OP_QUERY, 12'd2730, 12'd0);
      send_request(OP_QUERY, 12'd100, 12'd0);
      city_pool = '{0, 4095, 1365, 2730};
      random_requests(35);

      send_idle_pct = 45;
      recv_idle_pct = 21;
      random_requests(35);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_requests(35);
      hold_cycles = 400;
      for (int i = 0; i < 8; i++)
         send_request(OP_QUERY, city_pool[$urandom_range(city_pool.size() - 1)], 12'd0);
      drain();

      for (int i = 0; i < 3; i++) send_request(OP_ADD, 12'd3550, 12'd10);
      send_request(OP_MARK, 12'd3550, 12'd0);
      send_request(OP_QUERY, 12'd10, 12'd0);
      for (int i = 0; i < 6; i++) send_request(OP_QUERY, $urandom_range(3500, 3600), 12'd0);
      drain();

      $display("covered %0d edge adds, %0d marks, %0d checked queries",
               sb.adds_seen, sb.marks_seen, sb.queries_checked);
      $display("including repeated edges, self loops and a long response stall");
      if (sb.mismatches == 0 && sb.expected_distance.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
